// ===== rtl/glcd_pkg.sv =====
// Shared types and constants for the graphic LCD command byte generator.
package glcd_pkg;

   // Request modes
   localparam logic [2:0] MODE_CHAR        = 3'd0;
   localparam logic [2:0] MODE_STRING      = 3'd1;
   localparam logic [2:0] MODE_HEX         = 3'd2;
   localparam logic [2:0] MODE_GOTO        = 3'd3;
   localparam logic [2:0] MODE_PIXEL_SET   = 3'd4;
   localparam logic [2:0] MODE_PIXEL_CLEAR = 3'd5;

   // Configuration register indexes
   localparam logic CSR_GRAPHIC_COLUMNS = 1'b0;
   localparam logic CSR_ADDR_OPCODE     = 1'b1;

   localparam logic [7:0] GRAPHIC_COLUMNS_RESET = 8'd40;
   localparam logic [7:0] ADDR_OPCODE_RESET     = 8'd36;

   // Fixed bus values
   localparam logic [7:0]  WRITE_CMD      = 8'hC0;
   localparam logic [15:0] TEXT_BASE      = 16'h7B00;
   localparam logic [7:0]  PIXEL_SET_CMD  = 8'hFD;
   localparam logic [7:0]  PIXEL_CLR_CMD  = 8'hF5;
   localparam logic [7:0]  CHAR_FALLBACK  = 8'h3F;
   localparam logic [7:0]  CHAR_LOW       = 8'd32;
   localparam logic [7:0]  CHAR_HIGH      = 8'h9F;
   localparam logic [7:0]  HEX_DIGIT_OFS  = 8'h10;
   localparam logic [7:0]  HEX_LETTER_OFS = 8'h17;

   // Reciprocal for x/6 on 8-bit x: (x*171)>>10
   localparam logic [7:0] DIV6_RECIP = 8'd171;
   localparam int         DIV6_SHIFT = 10;

   // Depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   localparam int JOB_BYTES = 4;

   typedef struct packed {
      logic       is_command;
      logic [7:0] bus_byte;
   } bus_word_type;

   // One decoded request: up to four bus words and the index of the final one
   typedef struct packed {
      bus_word_type [JOB_BYTES-1:0] words;
      logic [1:0]                   last_idx;
   } job_type;

endpackage

// ===== rtl/glcd_ifs.sv =====
// Request and response channel interfaces.
interface glcd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [7:0] value;
   logic [7:0] pos_x;
   logic [7:0] pos_y;

   modport source (output valid, mode, value, pos_x, pos_y, input ready);
   modport sink   (input valid, mode, value, pos_x, pos_y, output ready);
endinterface

interface glcd_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_command;
   logic [7:0] bus_byte;
   logic       last;

   modport source (output valid, is_command, bus_byte, last, input ready);
   modport sink   (input valid, is_command, bus_byte, last, output ready);
endinterface

// ===== rtl/glcd_front.sv =====
// Front end: accepts requests, holds the configuration and decodes jobs.
module glcd_front #(
   parameter int TEXT_COLUMNS = 40,
   parameter int TEXT_ROWS    = 16
) (
   input  logic               clock,
   input  logic               reset,
   glcd_req_if.sink           req_bus,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [7:0]         csr_wdata,
   input  logic               queue_full,
   output logic               push,
   output glcd_pkg::job_type  push_job
);

   logic [7:0]  graphic_columns_ff;
   logic [7:0]  addr_opcode_ff;

   logic        has_words;
   logic [7:0]  char_code;
   logic [7:0]  row_c;
   logic [7:0]  col_c;
   logic [15:0] goto_adr;
   logic [15:0] div6_prod;
   logic [7:0]  px_div6;
   logic [7:0]  px_times6;
   logic [2:0]  px_rem6;
   logic [15:0] pixel_adr;
   logic [7:0]  bit_cmd_base;
   logic [15:0] line_adr;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         graphic_columns_ff <= glcd_pkg::GRAPHIC_COLUMNS_RESET;
         addr_opcode_ff     <= glcd_pkg::ADDR_OPCODE_RESET;
      end else if (csr_we) begin
         if (csr_index == glcd_pkg::CSR_GRAPHIC_COLUMNS) begin
            graphic_columns_ff <= csr_wdata;
         end else begin
            addr_opcode_ff <= csr_wdata;
         end
      end
   end

   assign req_bus.ready = !queue_full;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'd0, nib};
      return (nib > 4'd9) ? wide + glcd_pkg::HEX_LETTER_OFS
                          : wide + glcd_pkg::HEX_DIGIT_OFS;
   endfunction

   // Checked character substitution
   always_comb begin
      char_code = req_bus.value;
      if (req_bus.value < glcd_pkg::CHAR_LOW || req_bus.value > glcd_pkg::CHAR_HIGH) begin
         char_code = glcd_pkg::CHAR_FALLBACK;
      end
   end

   // Text cursor address with out-of-range clamp
   assign row_c    = (req_bus.pos_y > 8'(TEXT_ROWS - 1)) ? 8'd0 : req_bus.pos_y;
   assign col_c    = (req_bus.pos_x > 8'(TEXT_COLUMNS - 1)) ? 8'd0 : req_bus.pos_x;
   assign goto_adr = glcd_pkg::TEXT_BASE + 16'(TEXT_COLUMNS) * {8'd0, row_c}
                     + {8'd0, col_c};

   // Pixel address: columns*y + x/6, x/6 through a reciprocal multiply
   assign div6_prod = {8'd0, req_bus.pos_x} * {8'd0, glcd_pkg::DIV6_RECIP};
   assign px_div6   = 8'(div6_prod >> glcd_pkg::DIV6_SHIFT);
   assign px_times6 = {px_div6[6:0], 1'b0} + {px_div6[5:0], 2'b00};
   assign px_rem6   = 3'(req_bus.pos_x - px_times6);
   assign line_adr  = {8'd0, graphic_columns_ff} * {8'd0, req_bus.pos_y};
   assign pixel_adr = line_adr + {8'd0, px_div6};
   assign bit_cmd_base = (req_bus.mode == glcd_pkg::MODE_PIXEL_SET) ?
                         glcd_pkg::PIXEL_SET_CMD : glcd_pkg::PIXEL_CLR_CMD;

   // Mode decoder
   always_comb begin
      has_words = 1'b1;
      push_job  = '0;
      unique case (req_bus.mode)
         glcd_pkg::MODE_CHAR: begin
            push_job.words[0] = '{1'b0, char_code - glcd_pkg::CHAR_LOW};
            push_job.words[1] = '{1'b1, glcd_pkg::WRITE_CMD};
            push_job.last_idx = 2'd1;
         end
         glcd_pkg::MODE_STRING: begin
            has_words         = (req_bus.value != 8'd0);
            push_job.words[0] = '{1'b0, req_bus.value - glcd_pkg::CHAR_LOW};
            push_job.words[1] = '{1'b1, glcd_pkg::WRITE_CMD};
            push_job.last_idx = 2'd1;
         end
         glcd_pkg::MODE_HEX: begin
            push_job.words[0] = '{1'b0, hex_digit(req_bus.value[7:4])};
            push_job.words[1] = '{1'b1, glcd_pkg::WRITE_CMD};
            push_job.words[2] = '{1'b0, hex_digit(req_bus.value[3:0])};
            push_job.words[3] = '{1'b1, glcd_pkg::WRITE_CMD};
            push_job.last_idx = 2'd3;
         end
         glcd_pkg::MODE_GOTO: begin
            push_job.words[0] = '{1'b0, goto_adr[7:0]};
            push_job.words[1] = '{1'b0, goto_adr[15:8]};
            push_job.words[2] = '{1'b1, addr_opcode_ff};
            push_job.last_idx = 2'd2;
         end
         glcd_pkg::MODE_PIXEL_SET, glcd_pkg::MODE_PIXEL_CLEAR: begin
            push_job.words[0] = '{1'b0, pixel_adr[7:0]};
            push_job.words[1] = '{1'b0, pixel_adr[15:8]};
            push_job.words[2] = '{1'b1, addr_opcode_ff};
            push_job.words[3] = '{1'b1, bit_cmd_base - {5'd0, px_rem6}};
            push_job.last_idx = 2'd3;
         end
         default: begin
            // unused modes produce nothing
            has_words = 1'b0;
         end
      endcase
   end

   assign push = req_bus.valid && req_bus.ready && has_words;

endmodule

// ===== rtl/glcd_queue.sv =====
// Short job queue between the decoder and the byte sequencer.
module glcd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  glcd_pkg::job_type  push_job,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output glcd_pkg::job_type  head_job
);

   localparam int PtrWidth = (glcd_pkg::QUEUE_DEPTH > 1) ? $clog2(glcd_pkg::QUEUE_DEPTH) : 1;
   localparam int CntWidth = $clog2(glcd_pkg::QUEUE_DEPTH + 1);

   glcd_pkg::job_type slots_ff [glcd_pkg::QUEUE_DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   function automatic logic [PtrWidth-1:0] next_ptr(input logic [PtrWidth-1:0] p);
      return (p == PtrWidth'(glcd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full     = (count_ff == CntWidth'(glcd_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = slots_ff[rd_ptr_ff];

   // Pointer and fill-count update
   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/glcd_back.sv =====
// Back end: sends head job bytes, one per cycle unless stalled.
module glcd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  glcd_pkg::job_type  head_job,
   output logic               pop,
   glcd_rsp_if.source         rsp_bus
);

   logic       rsp_valid_ff;
   logic       is_command_ff;
   logic [7:0] bus_byte_ff;
   logic       last_ff;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       at_last;

   assign load    = !empty && (!rsp_valid_ff || rsp_bus.ready);
   assign at_last = (idx_ff == head_job.last_idx);
   assign pop     = load && at_last;
   assign idx_in  = at_last ? 2'd0 : idx_ff + 2'd1;

   // Word index and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            idx_ff       <= idx_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         is_command_ff <= head_job.words[idx_ff].is_command;
         bus_byte_ff   <= head_job.words[idx_ff].bus_byte;
         last_ff       <= at_last;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.is_command = is_command_ff;
   assign rsp_bus.bus_byte   = bus_byte_ff;
   assign rsp_bus.last       = last_ff;

endmodule

// ===== rtl/glcd_command_byte_generator.sv =====
// Top level of the graphic LCD command byte generator.
//
//   channel   direction  handshake          payload
//   req_bus   in         valid/ready        mode, value, pos_x, pos_y
//   rsp_bus   out        valid/ready        is_command, bus_byte, last
//   csr_*     in         csr_we, no ready   csr_index, csr_wdata
//
// A request is decoded in the cycle it is accepted and its bus bytes (2 to 4;
// none for a zero string byte or an unused mode) go into a two-entry job queue;
// the sequencer sends one byte per cycle while rsp_bus is not stalled. The first
// byte is registered in a queue slot and then in the single output register.
// Reset is synchronous, clears the queue and the sequencer and presets the
// configuration registers. req_bus.ready drops only while the job queue is full;
// rsp stalls hold the output register and back up into the queue.
module glcd_command_byte_generator #(
   parameter int TEXT_COLUMNS = 40,
   parameter int TEXT_ROWS    = 16
) (
   input  logic       clock,
   input  logic       reset,
   glcd_req_if.sink   req_bus,
   glcd_rsp_if.source rsp_bus,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   logic              push;
   logic              pop;
   logic              queue_full;
   logic              queue_empty;
   glcd_pkg::job_type push_job;
   glcd_pkg::job_type head_job;

   glcd_front #(
      .TEXT_COLUMNS (TEXT_COLUMNS),
      .TEXT_ROWS    (TEXT_ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   glcd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head_job (head_job)
   );

   glcd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (queue_empty),
      .head_job (head_job),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule
